// ----- design/sdcs_pkg.sv -----
// Shared types and constants for the SD card clock divider select block.
// No dependencies; used by sdcs_serial_div and sd_clock_divider_select_top.
package sdcs_pkg;

  localparam int SRC_W = 28;
  localparam int REQ_W = 32;
  localparam int ACH_W = 27;
  localparam int DIV_OUT_W = 8;
  localparam int QW = SRC_W - 2;
  localparam int DIV_W = REQ_W;
  localparam logic [SRC_W-1:0] SRC_RESET = 28'd104000000;

  typedef struct packed {
    logic busy;
    logic done;
  } sdcs_div_stat_t;

  typedef enum logic [3:0] {
    ST_CAL_START,
    ST_CAL_WAIT,
    ST_IDLE,
    ST_CLASSIFY,
    ST_GUESS_WAIT,
    ST_RATE,
    ST_RATE_WAIT,
    ST_CHECK,
    ST_EMIT
  } sdcs_state_t;

endpackage

// ----- design/sdcs_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on sdcs_pkg for widths and the status struct.
module sdcs_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sdcs_pkg::QW-1:0]       dividend,
  input  logic [sdcs_pkg::DIV_W-1:0]    divisor,
  output logic [sdcs_pkg::QW-1:0]       quotient,
  output sdcs_pkg::sdcs_div_stat_t      stat
);

  localparam int QW = sdcs_pkg::QW;
  localparam int DIV_W = sdcs_pkg::DIV_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [QW-1:0]    rem;
  logic [QW-1:0]    dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W-1:0] shifted;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign shifted = {{(DIV_W-QW-1){1'b0}}, rem, dvd[QW-1]};
  assign trial = {1'b0, shifted} - {1'b0, dsr};
  assign ge = !trial[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[QW-2:0], ge};
      rem <= ge ? trial[QW-1:0] : shifted[QW-1:0];
    end
  end

  assign quotient = dvd;
  assign stat.busy = busy;
  assign stat.done = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running division");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while still busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("divider busy with empty step count");

endmodule

// ----- design/sd_clock_divider_select_top.sv -----
// Top level of the SD card clock divider select block: sequencer and output register.
// Depends on sdcs_pkg and sdcs_serial_div.
//
// Takes one requested card-clock rate per beat and returns the divider and the rate it gives.
// Every division runs through one bit-serial divider at one quotient bit per cycle: 26 steps.
// A request with no step-up runs two divides between its beat and the result load: one for
// the first guess and one for the achieved rate. The guess leaves at most one step-up, which
// adds one more rate divide. Requests out of range, zero or above a quarter of the source skip
// the guess divide, and divider 0 skips the rate divide. The block returns to idle in the cycle
// after the load. After reset and after each write of the source rate the block works out the
// slowest rate and takes no beat meanwhile. A finished result waits in the output register
// while the next request is taken.
module sd_clock_divider_select_top #(
  parameter int DIVIDER_MAX = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sdcs_pkg::SRC_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sdcs_pkg::REQ_W-1:0]        requested_hz,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sdcs_pkg::DIV_OUT_W-1:0]    divider,
  output logic [sdcs_pkg::ACH_W-1:0]        achieved_hz,
  output logic                              above_range,
  output logic                              below_range
);

  localparam int SRC_W = sdcs_pkg::SRC_W;
  localparam int REQ_W = sdcs_pkg::REQ_W;
  localparam int ACH_W = sdcs_pkg::ACH_W;
  localparam int QW = sdcs_pkg::QW;
  localparam int DIV_W = sdcs_pkg::DIV_W;
  localparam int OW = sdcs_pkg::DIV_OUT_W;
  localparam int DW = $clog2(DIVIDER_MAX + 1);
  localparam logic [DW-1:0] DMAX_V = DW'(DIVIDER_MAX);

  sdcs_pkg::sdcs_state_t    state;
  sdcs_pkg::sdcs_state_t    state_next;
  sdcs_pkg::sdcs_div_stat_t div_stat;

  logic [SRC_W-1:0] src;
  logic [QW-1:0]    bottom;
  logic [REQ_W-1:0] req;
  logic [DW-1:0]    d;
  logic [ACH_W-1:0] rate;
  logic             above;
  logic             below;

  logic             div_start;
  logic [DIV_W-1:0] div_dsr;
  logic [QW-1:0]    div_q;
  logic [ACH_W-1:0] top;
  logic             cls_above;
  logic             cls_below;
  logic             cls_zero;
  logic             cls_req0;
  logic             step_up;
  logic             out_load;
  logic [DW+OW-1:0] d_ext;

  assign top = src[SRC_W-1:1];
  assign cls_above = req > {{(REQ_W-ACH_W){1'b0}}, top};
  assign cls_below = req < {{(REQ_W-QW){1'b0}}, bottom};
  assign cls_zero = (req == {{(REQ_W-ACH_W){1'b0}}, top})
                    || ({{(REQ_W+2-SRC_W){1'b0}}, src} < {req, 2'b00});
  assign cls_req0 = (req == '0);
  assign step_up = ({{(REQ_W-ACH_W){1'b0}}, rate} > req) && (d < DMAX_V);
  assign out_load = (state == sdcs_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign d_ext = {{OW{1'b0}}, d};

  sdcs_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (src[SRC_W-1:2]),
    .divisor  (div_dsr),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdcs_pkg::ST_CAL_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_dsr = DIV_W'(DIVIDER_MAX);
    in_stall = 1'b1;
    unique case (state)
      sdcs_pkg::ST_CAL_START: begin
        if (!div_stat.busy) begin
          div_start = 1'b1;
          state_next = sdcs_pkg::ST_CAL_WAIT;
        end
      end
      sdcs_pkg::ST_CAL_WAIT: begin
        if (div_stat.done) begin
          state_next = sdcs_pkg::ST_IDLE;
        end
      end
      sdcs_pkg::ST_IDLE: begin
        in_stall = cfg_write;
        if (in_valid && !cfg_write) begin
          state_next = sdcs_pkg::ST_CLASSIFY;
        end
      end
      sdcs_pkg::ST_CLASSIFY: begin
        if (cls_above || cls_below || cls_zero || cls_req0) begin
          state_next = sdcs_pkg::ST_RATE;
        end else begin
          div_dsr = req;
          div_start = 1'b1;
          state_next = sdcs_pkg::ST_GUESS_WAIT;
        end
      end
      sdcs_pkg::ST_GUESS_WAIT: begin
        if (div_stat.done) begin
          state_next = sdcs_pkg::ST_RATE;
        end
      end
      sdcs_pkg::ST_RATE: begin
        if (d == '0) begin
          state_next = sdcs_pkg::ST_CHECK;
        end else begin
          div_dsr = {{(DIV_W-DW){1'b0}}, d};
          div_start = 1'b1;
          state_next = sdcs_pkg::ST_RATE_WAIT;
        end
      end
      sdcs_pkg::ST_RATE_WAIT: begin
        if (div_stat.done) begin
          state_next = sdcs_pkg::ST_CHECK;
        end
      end
      sdcs_pkg::ST_CHECK: begin
        state_next = step_up ? sdcs_pkg::ST_RATE : sdcs_pkg::ST_EMIT;
      end
      sdcs_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = sdcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdcs_pkg::ST_CAL_START;
      end
    endcase
    if (cfg_write) begin
      state_next = sdcs_pkg::ST_CAL_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src <= sdcs_pkg::SRC_RESET;
    end else if (cfg_write) begin
      src <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sdcs_pkg::ST_CAL_WAIT && div_stat.done) begin
      bottom <= div_q;
    end
    if (state == sdcs_pkg::ST_IDLE && in_valid && !in_stall) begin
      req <= requested_hz;
    end
    if (state == sdcs_pkg::ST_CLASSIFY) begin
      above <= cls_above;
      below <= !cls_above && cls_below;
      if (cls_above) begin
        d <= '0;
      end else if (cls_below) begin
        d <= DMAX_V;
      end else if (cls_zero) begin
        d <= '0;
      end else if (cls_req0) begin
        d <= DMAX_V;
      end
    end
    if (state == sdcs_pkg::ST_GUESS_WAIT && div_stat.done) begin
      d <= (div_q > QW'(DIVIDER_MAX)) ? DMAX_V : div_q[DW-1:0];
    end
    if (state == sdcs_pkg::ST_RATE && d == '0) begin
      rate <= top;
    end
    if (state == sdcs_pkg::ST_RATE_WAIT && div_stat.done) begin
      rate <= {{(ACH_W-QW){1'b0}}, div_q};
    end
    if (state == sdcs_pkg::ST_CHECK && step_up) begin
      d <= d + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      divider <= d_ext[OW-1:0];
      achieved_hz <= rate;
      above_range <= above;
      below_range <= below;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(above_range && below_range)) else $error("both range flags set");
  a_above_div_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && above_range |-> divider == '0) else $error("above range with nonzero divider");
  a_accept_classify: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == sdcs_pkg::ST_CLASSIFY)
    else $error("accepted beat not classified");
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy) else $error("division started while divider busy");

endmodule
